>>> rtl/core/lcsu_pkg.sv
package lcsu_pkg;

	// Fixed geometry of the device protocol
	localparam int unsigned CELL_W      = 4;
	localparam int unsigned TEXT_MAX    = 20;
	localparam int unsigned MAX_RESULTS = 5;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned TEXT_BITS   = 160;

	// Function codes of an input item
	localparam logic FUNC_TEXT  = 1'b0;
	localparam logic FUNC_LIGHT = 1'b1;

	// Report type byte (byte 1 of a report)
	localparam logic [7:0] RPT_LIGHT = 8'h00;
	localparam logic [7:0] RPT_CELL  = 8'h01;

	typedef struct packed {
		logic        func;
		logic        row;
		logic [4:0]  start_column;
		logic [4:0]  text_length;
		logic [63:0] text_first;
		logic [63:0] text_second;
		logic [31:0] text_third;
		logic [2:0]  light_index;
		logic        light_state;
	} req_item_t;

	typedef struct packed {
		logic [63:0] report;
		logic        last_report;
	} rpt_item_t;

	// Where new characters land inside one 4-character cell
	typedef struct packed {
		logic [1:0] offset;
		logic [2:0] take;
	} cell_ctl_t;

endpackage

>>> rtl/core/lcd_cell_shadow_updater.sv
// Channel | Handshake            | Payload    | Moves
// --------+----------------------+------------+------------------------------------
// req     | req_valid/req_ready  | req_item_t | one text write or light write
// rpt     | rpt_valid/rpt_ready  | rpt_item_t | one 8-byte report, last flag per item
//
// Flow: one item at a time. A text write is transferred, then takes one compare step per
// 4-character cell it touches (next cell read overlaps the current compare/write)
// and a flush step. A light write that changes the light goes to the flush step;
// an unchanged light or a text write that touches no cell ends at the transfer.
// Reset: cell valid bits, light shadow and control clear at once; no clearing pass.
// Stalls: a changed cell with a report already held, or the flush, waits on a full output.
module lcd_cell_shadow_updater import lcsu_pkg::*; #(
	parameter int unsigned SCREEN_COLUMNS = 20,
	parameter int unsigned SCREEN_ROWS    = 2,
	parameter int unsigned NUM_LIGHTS     = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rpt_valid,
	input  logic      rpt_ready,
	output rpt_item_t rpt
);

	localparam int unsigned CPR     = SCREEN_COLUMNS / CELL_W;
	localparam int unsigned USABLE  = CPR * CELL_W;
	localparam int unsigned NCELL   = SCREEN_ROWS * CPR;
	localparam int unsigned AW      = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int unsigned CW      = $clog2(USABLE + CELL_W + 1);
	localparam int unsigned LIW     = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CMP   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;

	// Per-item working registers
	logic [CW-1:0]        col_q;
	logic [4:0]           left_q;
	logic [TEXT_BITS-1:0] text_q;
	logic [AW-1:0]        addr_q;
	logic [CNT_W-1:0]     cnt_q;

	// One report held back until we know whether it is the last
	logic                 pend_valid_q;
	logic [63:0]          pend_q;

	// Output register
	logic                 out_valid_q;
	rpt_item_t            out_q;
	logic                 out_load;

	logic [NUM_LIGHTS-1:0] light_q;

	// Memory port signals
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	logic          wr_en;

	// Compare step
	cell_ctl_t     ctl;
	logic [31:0]   merged;
	logic          changed;
	logic          out_free;
	logic          go;
	logic          more;
	logic [CW-1:0] col_n;
	logic [4:0]    left_n;
	logic [CNT_W-1:0] cnt_n;
	logic [63:0]   cell_rpt;

	// Accept-time decode
	logic          accept;
	logic          text_ok;
	logic          light_ok;
	logic          light_chg;
	logic [LIW-1:0] light_idx;
	logic [AW-1:0] addr_in;
	logic [4:0]    len_clamped;
	logic [2:0]    room;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rpt_ready;

	always_comb begin
		text_ok = (32'(req.row) < SCREEN_ROWS) && (32'(req.start_column) < USABLE)
			&& (req.text_length != 5'd0);
		len_clamped = (32'(req.text_length) > TEXT_MAX) ? 5'(TEXT_MAX) : req.text_length;
		addr_in = AW'(32'(req.row) * CPR + 32'(req.start_column[4:2]));
		light_ok  = (32'(req.light_index) < NUM_LIGHTS);
		light_idx = LIW'(32'(req.light_index));
		light_chg = light_ok && (light_q[light_idx] != req.light_state);
	end

	// Cell geometry for the compare step
	always_comb begin
		ctl.offset = col_q[1:0];
		room       = 3'(CELL_W) - {1'b0, col_q[1:0]};
		ctl.take   = (32'(left_q) < 32'(room)) ? left_q[2:0] : room;
		col_n      = col_q + CW'(ctl.take);
		left_n     = left_q - 5'(ctl.take);
		cnt_n      = changed ? cnt_q + CNT_W'(1) : cnt_q;
		more       = (left_n != 5'd0) && (32'(col_n) < USABLE) && (32'(cnt_n) < MAX_RESULTS);
		// Hold while a second report would need the full output register
		go         = !(changed && pend_valid_q) || out_free;
		cell_rpt   = {8'h00, merged, 8'(addr_q), RPT_CELL, 8'h00};
	end

	// Move the held report into the output register
	assign out_load = ((state_q == ST_CMP) && go && changed && pend_valid_q)
		|| ((state_q == ST_FLUSH) && pend_valid_q && out_free);

	lcsu_merge u_merge (
		.old_cell (rd_data),
		.chars    (text_q[31:0]),
		.ctl      (ctl),
		.merged   (merged),
		.changed  (changed)
	);

	// Read the first cell on transfer, the next cell while writing the current one
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_in;
		if (accept && (req.func == FUNC_TEXT) && text_ok) begin
			rd_en = 1'b1;
		end else if ((state_q == ST_CMP) && go && more) begin
			rd_en   = 1'b1;
			rd_addr = addr_q + AW'(1);
		end
	end

	assign wr_en = (state_q == ST_CMP) && go && changed;

	lcsu_cell_mem #(
		.DEPTH (NCELL),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (merged)
	);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			light_q      <= '0;
			cnt_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rpt_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req.func == FUNC_LIGHT) begin
							if (light_chg) begin
								light_q[light_idx] <= req.light_state;
								pend_valid_q       <= 1'b1;
								state_q            <= ST_FLUSH;
							end
						end else if (text_ok) begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (go) begin
						cnt_q <= cnt_n;
						if (changed) begin
							pend_valid_q <= 1'b1;
						end
						state_q <= more ? ST_CMP : ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					col_q  <= CW'(req.start_column);
					left_q <= len_clamped;
					text_q <= {req.text_third, req.text_second, req.text_first};
					addr_q <= addr_in;
					pend_q <= {32'h0, 7'h0, req.light_state, 5'h0, req.light_index,
						RPT_LIGHT, 8'h00};
				end
			end
			ST_CMP: begin
				if (go) begin
					col_q  <= col_n;
					left_q <= left_n;
					// Drop the characters just placed
					text_q <= text_q >> {ctl.take, 3'b000};
					if (more) begin
						addr_q <= addr_q + AW'(1);
					end
					if (changed) begin
						pend_q <= cell_rpt;
						if (pend_valid_q) begin
							out_q.report      <= pend_q;
							out_q.last_report <= 1'b0;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (pend_valid_q && out_free) begin
					out_q.report      <= pend_q;
					out_q.last_report <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rpt_valid = out_valid_q;
	assign rpt       = out_q;

	// A new item never starts with a report still held back
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !pend_valid_q)
		else $error("held report left over at idle");

	// Shadow cells are written only by the compare step
	a_wr_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CMP) && changed)
		else $error("cell write outside compare step");

	// A report that is not the last leaves another one held back
	a_not_last_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && !rpt.last_report) |-> pend_valid_q)
		else $error("non-final report with nothing to follow");

	// Report count per item stays within the cap
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (32'(cnt_q) < MAX_RESULTS))
		else $error("report count past cap");

endmodule

>>> rtl/core/lcsu_cell_mem.sv
module lcsu_cell_mem import lcsu_pkg::*; #(
	parameter int unsigned DEPTH = 10,
	parameter int unsigned AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);

	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [31:0]      rd_data_q;
	logic             rd_vld_q;

	// Entry never written reads as blank (all zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : 32'h0;

endmodule

>>> rtl/core/lcsu_merge.sv
module lcsu_merge import lcsu_pkg::*; (
	input  logic [31:0] old_cell,
	input  logic [31:0] chars,
	input  cell_ctl_t   ctl,
	output logic [31:0] merged,
	output logic        changed
);

	always_comb begin
		merged = old_cell;
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 4; k++) begin
				if ((k + int'(ctl.offset) == j) && (k < int'(ctl.take))) begin
					merged[8*j +: 8] = chars[8*k +: 8];
				end
			end
		end
		changed = (merged != old_cell);
	end

endmodule

>>> tb/lcsu_report_checker.sv
module lcsu_report_checker import lcsu_pkg::*; #(
	parameter int unsigned SCREEN_COLUMNS = 20,
	parameter int unsigned SCREEN_ROWS    = 2,
	parameter int unsigned NUM_LIGHTS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_item_t   req,
	input  logic        rpt_valid,
	input  logic        rpt_ready,
	input  rpt_item_t   rpt,
	output int unsigned fail_count,
	output int unsigned due_count,
	output int unsigned reports_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CELLS_PER_ROW  = SCREEN_COLUMNS / CELL_W;
	localparam int unsigned USABLE_COLUMNS = CELLS_PER_ROW * CELL_W;
	localparam int unsigned MAX_SHOWN      = 10;

	logic [7:0] screen_copy [SCREEN_ROWS * SCREEN_COLUMNS];
	logic       light_copy [NUM_LIGHTS];
	rpt_item_t  reports_due [$];

	// Merge one write into the shadow copy and queue the reports it should cause
	task automatic merge_write(input req_item_t w);
		int unsigned col, left, pos, base, offset, take, k, made, cell_no, addr;
		logic [7:0]   merged [CELL_W];
		logic [159:0] chars;
		logic         changed;
		rpt_item_t    r;
		made = 0;
		if (w.func == FUNC_LIGHT) begin
			if (w.light_index < NUM_LIGHTS && light_copy[w.light_index] != w.light_state) begin
				light_copy[w.light_index] = w.light_state;
				r.report = {32'h0, 7'h0, w.light_state, 5'h0, w.light_index, RPT_LIGHT, 8'h00};
				r.last_report = 1'b1;
				reports_due = {reports_due, r};
			end
		end else begin
			chars = {w.text_third, w.text_second, w.text_first};
			col   = w.start_column;
			left  = w.text_length;
			pos   = 0;
			if (left > TEXT_MAX)
				left = TEXT_MAX;
			if (w.row < SCREEN_ROWS && col < USABLE_COLUMNS) begin
				while (left > 0 && col < USABLE_COLUMNS && made < MAX_RESULTS) begin
					base   = (col / CELL_W) * CELL_W;
					offset = col % CELL_W;
					take   = CELL_W - offset;
					if (take > left)
						take = left;
					addr = w.row * SCREEN_COLUMNS + base;
					for (k = 0; k < CELL_W; k++)
						merged[k] = screen_copy[addr + k];
					for (k = 0; k < take; k++)
						merged[offset + k] = chars[8 * (pos + k) +: 8];
					changed = 1'b0;
					for (k = 0; k < CELL_W; k++)
						if (merged[k] != screen_copy[addr + k])
							changed = 1'b1;
					if (changed) begin
						cell_no = w.row * CELLS_PER_ROW + base / CELL_W;
						for (k = 0; k < CELL_W; k++)
							screen_copy[addr + k] = merged[k];
						r.report = {8'h00, merged[3], merged[2], merged[1], merged[0],
							8'(cell_no), RPT_CELL, 8'h00};
						r.last_report = 1'b0;
						reports_due = {reports_due, r};
						made++;
					end
					pos  += take;
					left -= take;
					col  += take;
				end
			end
			if (made > 0)
				reports_due[reports_due.size() - 1].last_report = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rpt_item_t want;
		if (!arst_n) begin
			foreach (screen_copy[i])
				screen_copy[i] = 8'h00;
			foreach (light_copy[i])
				light_copy[i] = 1'b0;
			reports_due.delete();
			fail_count      = 0;
			due_count       = 0;
			reports_checked = 0;
		end else begin
			// Check the report first: one taken in this cycle cannot belong to a
			// write taken in the same cycle
			if (rpt_valid && rpt_ready) begin
				reports_checked++;
				if (reports_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("%0t: report %h last %0b with nothing expected",
							$realtime, rpt.report, rpt.last_report);
				end else begin
					want = reports_due.pop_front();
					if (rpt.report !== want.report || rpt.last_report !== want.last_report) begin
						fail_count++;
						if (fail_count <= MAX_SHOWN)
							$display("%0t: report expected %h got %h, last expected %0b got %0b",
								$realtime, want.report, rpt.report,
								want.last_report, rpt.last_report);
					end
				end
			end
			if (req_valid && req_ready)
				merge_write(req);
			due_count = reports_due.size();
		end
	end

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lcsu_pkg::*;

	localparam int unsigned COLS         = 20;
	localparam int unsigned ROWS         = 2;
	localparam int unsigned LIGHTS       = 8;
	// Random writes per idling phase; three phases give about 420 in all
	localparam int unsigned PHASE_ITEMS  = 140;
	// Long receiver hold-off, long enough to back the block up into its input
	localparam int unsigned HOLD_CYCLES  = 200;
	// Cycles without any transfer before the run is called hung
	localparam int unsigned QUIET_LIMIT  = 5000;
	// Settling time after the last report
	localparam int unsigned DRAIN_CYCLES = 20;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '0;
	logic      rpt_valid;
	logic      rpt_ready = 1'b0;
	rpt_item_t rpt;

	// Idling knobs, written by the stimulus and read by the drivers
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_orders = 0;

	int unsigned fail_count, due_count, reports_checked;
	int unsigned text_sent  = 0;
	int unsigned light_sent = 0;
	req_item_t   last_text  = '0;

	lcd_cell_shadow_updater #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS   (ROWS),
		.NUM_LIGHTS    (LIGHTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rpt_valid(rpt_valid),
		.rpt_ready(rpt_ready),
		.rpt      (rpt)
	);

	lcsu_report_checker #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS   (ROWS),
		.NUM_LIGHTS    (LIGHTS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rpt_valid      (rpt_valid),
		.rpt_ready      (rpt_ready),
		.rpt            (rpt),
		.fail_count     (fail_count),
		.due_count      (due_count),
		.reports_checked(reports_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Build a text write; light fields stay zero since the block ignores them here
	function automatic req_item_t text_item(input logic row, input int unsigned col,
		input int unsigned len, input logic [159:0] chars);
		req_item_t item;
		item              = '0;
		item.func         = FUNC_TEXT;
		item.row          = row;
		item.start_column = 5'(col);
		item.text_length  = 5'(len);
		{item.text_third, item.text_second, item.text_first} = chars;
		return item;
	endfunction

	function automatic req_item_t light_item(input int unsigned index, input logic state);
		req_item_t item;
		item             = '0;
		item.func        = FUNC_LIGHT;
		item.light_index = 3'(index);
		item.light_state = state;
		return item;
	endfunction

	// Random write. Every field gets random bits, then text writes are shaped:
	// mostly in-range columns and lengths, a share of repeats of the previous
	// text write (which change nothing or little) and a share of text from a
	// two-letter alphabet, so unchanged cells are common as well.
	function automatic req_item_t random_item();
		req_item_t   item;
		int unsigned mode, i;
		item.func         = ($urandom_range(0, 99) < 30) ? FUNC_LIGHT : FUNC_TEXT;
		item.row          = 1'($urandom_range(0, 1));
		item.start_column = 5'($urandom);
		item.text_length  = 5'($urandom);
		item.text_first   = {$urandom, $urandom};
		item.text_second  = {$urandom, $urandom};
		item.text_third   = $urandom;
		item.light_index  = 3'($urandom);
		item.light_state  = 1'($urandom_range(0, 1));
		if (item.func == FUNC_TEXT) begin
			mode = $urandom_range(0, 99);
			if (mode < 10)
				return last_text;
			// Keep the raw 5-bit column now and then: columns past the screen do nothing
			if (mode >= 16)
				item.start_column = 5'($urandom_range(0, COLS - 1));
			if ($urandom_range(0, 99) < 8)
				item.text_length = 5'($urandom_range(TEXT_MAX + 1, 31));
			else
				item.text_length = 5'($urandom_range(0, TEXT_MAX));
			if (mode >= 55) begin
				for (i = 0; i < 8; i++) begin
					item.text_first[8 * i +: 8]  = $urandom_range(0, 1) ? 8'h2a : 8'h2d;
					item.text_second[8 * i +: 8] = $urandom_range(0, 1) ? 8'h2a : 8'h2d;
				end
				for (i = 0; i < 4; i++)
					item.text_third[8 * i +: 8] = $urandom_range(0, 1) ? 8'h2a : 8'h2d;
			end
		end
		return item;
	endfunction

	// Offer one write and hold it until the block takes it. Idle cycles come
	// first; with no idling, valid stays high straight into the next item.
	task automatic send_item(input req_item_t item);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = item;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
		if (item.func == FUNC_LIGHT) begin
			light_sent++;
		end else begin
			text_sent++;
			last_text = item;
		end
	endtask

	// Report receiver: sample the knobs at the rising edge, drive ready at the
	// falling edge. A new hold order blocks the channel for HOLD_CYCLES.
	initial begin : receiver
		int unsigned hold_left, served, idle_pct;
		hold_left = 0;
		served    = 0;
		idle_pct  = 0;
		forever begin
			@(posedge clk);
			idle_pct = rx_idle_pct;
			if (hold_orders != served) begin
				served    = hold_orders;
				hold_left = HOLD_CYCLES;
			end
			@(negedge clk);
			if (hold_left > 0) begin
				rpt_ready = 1'b0;
				hold_left--;
			end else begin
				rpt_ready = ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// Watchdog: end the run if neither channel moves a transfer for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rpt_valid && rpt_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		logic [159:0] ramp, ones, stripe;
		int unsigned  n;
		for (n = 0; n < 20; n++) begin
			ramp[8 * n +: 8]   = 8'(8'h41 + n);
			stripe[8 * n +: 8] = 8'h5a;
		end
		ones = '1;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Phase one: sender idles lightly, receiver heavily
		tx_idle_pct = 15;
		rx_idle_pct = 69;

		// Directed writes, starting from an all-zero shadow
		send_item(text_item(0, 0, 20, ramp));     // whole row: five cell reports
		send_item(text_item(0, 0, 20, ramp));     // same text again: nothing changes
		send_item(text_item(0, 7, 0, ones));      // zero length
		send_item(text_item(1, 0, 31, ones));     // length above 20 clamps to 20
		send_item(text_item(1, 18, 5, stripe));   // runs past the row end: tail dropped
		send_item(text_item(0, 20, 4, ones));     // start column past the last cell
		send_item(text_item(1, 31, 20, ramp));    // largest start column
		send_item(text_item(0, 3, 2, stripe));    // straddles two cells
		send_item(text_item(0, 19, 1, ones));     // last column only
		send_item(text_item(0, 0, 20, '0));       // clear row back to zero
		send_item(text_item(0, 0, 20, '0));       // and again: nothing
		send_item(text_item(1, 0, 20, ones));     // only the tail cell differs
		send_item(text_item(0, 1, 16, ramp));     // unaligned start and end
		send_item(light_item(0, 1'b1));
		send_item(light_item(0, 1'b1));           // same state: no report
		send_item(light_item(7, 1'b1));
		send_item(light_item(7, 1'b0));
		send_item(light_item(3, 1'b0));           // already off: no report
		send_item(light_item(4, 1'b1));

		for (n = 0; n < PHASE_ITEMS; n++)
			send_item(random_item());

		// Phase two: the other way round, with a pause that drains every report
		tx_idle_pct = 69;
		rx_idle_pct = 15;
		for (n = 0; n < PHASE_ITEMS / 2; n++)
			send_item(random_item());
		req_valid = 1'b0;
		while (due_count != 0)
			@(negedge clk);
		for (n = 0; n < PHASE_ITEMS / 2; n++)
			send_item(random_item());

		// Phase three: no idling. Open with a long receiver hold-off while the
		// sender keeps offering writes, so the block backs up into its input.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_orders++;
		for (n = 0; n < PHASE_ITEMS; n++)
			send_item(random_item());

		// Wait for the last report, then give the block time to misbehave
		req_valid = 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d text writes and %0d light writes over three idling phases,",
			text_sent, light_sent);
		$display("a %0d-cycle report hold-off and a full drain pause; %0d reports checked.",
			HOLD_CYCLES, reports_checked);
		if (fail_count == 0 && due_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
